// File: sv/frc_pkg.sv
// Shared constants, payload types and BCD helper functions for the frame clock latch.
package frc_pkg;

   localparam int START_WIDTH = 17;
   localparam logic [16:0] START_RESET = 17'd36000;

   localparam logic [16:0] FRAME_MUL = 17'd70224;
   localparam int DOT_SHIFT = 22;

   localparam logic [16:0] DAY_SECONDS = 17'd86400;
   localparam logic [11:0] HOUR_SECONDS = 12'd3600;
   localparam logic [5:0] MINUTE_SECONDS = 6'd60;

   // Reciprocals: days = (t >> 7) / 675, hours = (rem >> 4) / 225, minutes = (rest >> 2) / 15.
   localparam logic [25:0] DAY_RECIP = 26'd50903317;
   localparam int DAY_RECIP_SHIFT = 35;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam int HOUR_RECIP_SHIFT = 21;
   localparam logic [10:0] MINUTE_RECIP = 11'd1093;
   localparam int MINUTE_RECIP_SHIFT = 14;

   localparam int DH_BIT8 = 0;
   localparam int DH_HALT = 6;
   localparam int DH_STICKY = 7;

   localparam logic [6:0] SPAN_MAX = 7'd97;

   typedef struct packed {
      logic [31:0] frame_count;
      logic [7:0]  day_low;
      logic [7:0]  day_high;
      logic [7:0]  hours;
      logic [7:0]  minutes;
      logic [7:0]  seconds;
   } raw_type;

   typedef struct packed {
      logic [26:0] elapsed;
      logic [25:0] new_time;
      logic [16:0] new_sec;
      logic        canon;
      logic [7:0]  day_low;
      logic [7:0]  day_high;
   } prep_type;

   typedef struct packed {
      logic [31:0] cur_time;
      logic [15:0] days;
      logic        halted;
      logic        carry;
   } latch_type;

   function automatic logic [4:0] hours_of_bcd(input logic [7:0] b);
      logic [5:0] raw;
      raw = 6'(b[5:4]) * 6'd10 + 6'(b[3:0]);
      return (raw >= 6'd24) ? 5'(raw - 6'd24) : 5'(raw);
   endfunction

   function automatic logic [5:0] sexa_of_bcd(input logic [7:0] b);
      logic [6:0] raw;
      raw = 7'(b[6:4]) * 7'd10 + 7'(b[3:0]);
      return (raw >= 7'd60) ? 6'(raw - 7'd60) : 6'(raw);
   endfunction

   function automatic logic hours_canon(input logic [7:0] b);
      return (b[7:6] == 2'd0) && (b[3:0] <= 4'd9) &&
             ((b[5:4] < 2'd2) || ((b[5:4] == 2'd2) && (b[3:0] <= 4'd3)));
   endfunction

   function automatic logic sexa_canon(input logic [7:0] b);
      return !b[7] && (b[6:4] <= 3'd5) && (b[3:0] <= 4'd9);
   endfunction

   function automatic logic [5:0] hours_to_bcd(input logic [4:0] h);
      logic [1:0] tens;
      logic [4:0] base;
      if (h >= 5'd20) begin
         tens = 2'd2;
         base = 5'd20;
      end else if (h >= 5'd10) begin
         tens = 2'd1;
         base = 5'd10;
      end else begin
         tens = 2'd0;
         base = 5'd0;
      end
      return {tens, 4'(h - base)};
   endfunction

   function automatic logic [6:0] sexa_to_bcd(input logic [5:0] v);
      logic [2:0] tens;
      logic [5:0] base;
      if (v >= 6'd50) begin
         tens = 3'd5;
         base = 6'd50;
      end else if (v >= 6'd40) begin
         tens = 3'd4;
         base = 6'd40;
      end else if (v >= 6'd30) begin
         tens = 3'd3;
         base = 6'd30;
      end else if (v >= 6'd20) begin
         tens = 3'd2;
         base = 6'd20;
      end else if (v >= 6'd10) begin
         tens = 3'd1;
         base = 6'd10;
      end else begin
         tens = 3'd0;
         base = 6'd0;
      end
      return {tens, 4'(v - base)};
   endfunction

endpackage

// File: sv/frc_if.sv
// Request and response channel interfaces of the frame clock latch.
interface frc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] frame_count;
   logic [7:0]  day_low_in;
   logic [7:0]  day_high_in;
   logic [7:0]  hours_in;
   logic [7:0]  minutes_in;
   logic [7:0]  seconds_in;

   modport source (output valid, frame_count, day_low_in, day_high_in, hours_in, minutes_in,
                   seconds_in, input ready);
   modport sink (input valid, frame_count, day_low_in, day_high_in, hours_in, minutes_in,
                 seconds_in, output ready);
endinterface

interface frc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] day_low_out;
   logic [7:0] day_high_out;
   logic [5:0] hours_bcd;
   logic [6:0] minutes_bcd;
   logic [6:0] seconds_bcd;

   modport source (output valid, day_low_out, day_high_out, hours_bcd, minutes_bcd,
                   seconds_bcd, input ready);
   modport sink (input valid, day_low_out, day_high_out, hours_bcd, minutes_bcd, seconds_bcd,
                 output ready);
endinterface

// File: sv/frc_prep.sv
// Input register and state-independent work: elapsed seconds and decoded host time.
module frc_prep (
   input  logic              clock,
   input  logic              reset,
   frc_req_if.sink           req_chan,
   output logic              out_valid,
   input  logic              out_ready,
   output frc_pkg::prep_type out_data
);
   import frc_pkg::*;

   logic        s0_v_ff, s0_v_in;
   raw_type     s0_ff, s0_in;
   logic        s1_v_ff, s1_v_in;
   prep_type    s1_ff, s1_in;
   logic        s0_ready;
   logic        s1_ready;
   logic [48:0] frame_prod;
   logic [4:0]  hh;
   logic [5:0]  mm;
   logic [5:0]  ss;
   logic [16:0] sec_of_day;
   logic [8:0]  day_idx;

   assign s1_ready = !s1_v_ff || out_ready;
   assign s0_ready = !s0_v_ff || s1_ready;
   assign req_chan.ready = s0_ready;

   assign frame_prod = 49'(s0_ff.frame_count) * 49'(FRAME_MUL);
   assign hh = hours_of_bcd(s0_ff.hours);
   assign mm = sexa_of_bcd(s0_ff.minutes);
   assign ss = sexa_of_bcd(s0_ff.seconds);
   assign sec_of_day = 17'(hh) * 17'(HOUR_SECONDS) + 17'(mm) * 17'(MINUTE_SECONDS) + 17'(ss);
   assign day_idx = {s0_ff.day_high[DH_BIT8], s0_ff.day_low};

   always_comb begin
      s0_v_in = s0_ready ? req_chan.valid : s0_v_ff;
      s1_v_in = s1_ready ? s0_v_ff : s1_v_ff;
   end

   always_comb begin
      s0_in = s0_ff;
      if (req_chan.valid && s0_ready) begin
         s0_in.frame_count = req_chan.frame_count;
         s0_in.day_low = req_chan.day_low_in;
         s0_in.day_high = req_chan.day_high_in;
         s0_in.hours = req_chan.hours_in;
         s0_in.minutes = req_chan.minutes_in;
         s0_in.seconds = req_chan.seconds_in;
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (s0_v_ff && s1_ready) begin
         s1_in.elapsed = frame_prod[DOT_SHIFT +: 27];
         s1_in.new_sec = sec_of_day;
         s1_in.new_time = 26'(day_idx) * 26'(DAY_SECONDS) + 26'(sec_of_day);
         s1_in.canon = hours_canon(s0_ff.hours) && sexa_canon(s0_ff.minutes) &&
                       sexa_canon(s0_ff.seconds);
         s1_in.day_low = s0_ff.day_low;
         s1_in.day_high = s0_ff.day_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= s0_v_in;
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   assign out_valid = s1_v_ff;
   assign out_data = s1_ff;

endmodule

// File: sv/frc_state.sv
// Clock state: halt, adoption of host bytes, sticky carry and the shadow of the last latch.
module frc_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [frc_pkg::START_WIDTH-1:0]     csr_wdata,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  frc_pkg::prep_type                   in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output frc_pkg::latch_type                  out_data
);
   import frc_pkg::*;

   logic        v_ff, v_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] frozen_ff, frozen_in;
   logic        halted_ff, halted_in;
   logic        carry_ff, carry_in;
   logic [6:0]  span_ff, span_in;
   logic [31:0] time_ff, time_in;
   logic [15:0] days_ff, days_in;

   logic        take;
   logic [7:0]  shadow_high;
   logic [16:0] shadow_sec;
   logic        same_bytes;
   logic        changed;
   logic        high_diff;
   logic [31:0] keep_time;
   logic [50:0] day_prod;
   logic [15:0] keep_days;
   logic [31:0] time_new;
   logic [15:0] days_new;
   logic [6:0]  span_new;

   assign in_ready = !v_ff || out_ready;
   assign take = in_valid && in_ready;

   // The shadow is kept in binary; canonical host bytes compare equal to it exactly.
   assign shadow_high = {carry_ff, halted_ff, 5'b00000, days_ff[8]};
   assign shadow_sec = 17'(time_ff - 32'(days_ff) * 32'(DAY_SECONDS));
   assign high_diff = in_data.day_high != shadow_high;
   assign same_bytes = in_data.canon && !high_diff && (in_data.day_low == days_ff[7:0]) &&
                       (in_data.new_sec == shadow_sec);
   assign changed = !same_bytes;

   assign keep_time = halted_ff ? frozen_ff : 32'(in_data.elapsed) + offset_ff;
   assign day_prod = 51'(keep_time[31:7]) * 51'(DAY_RECIP);
   assign keep_days = day_prod[DAY_RECIP_SHIFT +: 16];

   assign time_new = changed ? 32'(in_data.new_time) : keep_time;
   assign days_new = changed ? 16'({in_data.day_high[DH_BIT8], in_data.day_low}) : keep_days;
   assign span_new = days_new[15:9];

   always_comb begin
      v_in = in_ready ? in_valid : v_ff;
      offset_in = offset_ff;
      frozen_in = frozen_ff;
      halted_in = halted_ff;
      carry_in = carry_ff;
      span_in = span_ff;
      time_in = time_ff;
      days_in = days_ff;
      if (csr_we) begin
         offset_in = 32'(csr_wdata);
      end else if (take) begin
         halted_in = in_data.day_high[DH_HALT];
         carry_in = (high_diff ? in_data.day_high[DH_STICKY] : carry_ff) || (span_new > span_ff);
         span_in = span_new;
         time_in = time_new;
         days_in = days_new;
         if (changed) begin
            if (in_data.day_high[DH_HALT]) begin
               frozen_in = 32'(in_data.new_time);
            end else begin
               offset_in = 32'(in_data.new_time) - 32'(in_data.elapsed);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
         offset_ff <= 32'(START_RESET);
         frozen_ff <= '0;
         halted_ff <= 1'b0;
         carry_ff <= 1'b0;
         span_ff <= '0;
         time_ff <= '0;
         days_ff <= '0;
      end else begin
         v_ff <= v_in;
         offset_ff <= offset_in;
         frozen_ff <= frozen_in;
         halted_ff <= halted_in;
         carry_ff <= carry_in;
         span_ff <= span_in;
         time_ff <= time_in;
         days_ff <= days_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data.cur_time = time_ff;
   assign out_data.days = days_ff;
   assign out_data.halted = halted_ff;
   assign out_data.carry = carry_ff;

   assert property (@(posedge clock) disable iff (reset)
      (days_ff[15:9] == span_ff) && (span_ff <= SPAN_MAX))
      else $error("span count does not follow the latched day count");

   assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (time_ff == frozen_ff))
      else $error("halted clock latched a time other than the frozen time");

   assert property (@(posedge clock) disable iff (reset)
      (take && changed && !csr_we) |=> (time_ff == 32'($past(in_data.new_time))))
      else $error("adopted host time was not latched");

endmodule

// File: sv/frc_split.sv
// Splits the latched time into day bytes and BCD hours, minutes and seconds.
module frc_split (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  frc_pkg::latch_type in_data,
   frc_rsp_if.source          rsp_chan
);
   import frc_pkg::*;

   typedef struct packed {
      logic [8:0] day;
      logic       halted;
      logic       carry;
   } tag_type;

   logic        a_v_ff, a_v_in;
   logic [16:0] a_rem_ff, a_rem_in;
   tag_type     a_tag_ff, a_tag_in;
   logic        b_v_ff, b_v_in;
   logic [4:0]  b_hour_ff, b_hour_in;
   logic [11:0] b_rest_ff, b_rest_in;
   tag_type     b_tag_ff, b_tag_in;
   logic        o_v_ff, o_v_in;
   logic [7:0]  o_day_low_ff, o_day_low_in;
   logic [7:0]  o_day_high_ff, o_day_high_in;
   logic [5:0]  o_hours_ff, o_hours_in;
   logic [6:0]  o_minutes_ff, o_minutes_in;
   logic [6:0]  o_seconds_ff, o_seconds_in;

   logic        a_ready;
   logic        b_ready;
   logic        o_ready;
   logic [26:0] hour_prod;
   logic [4:0]  hour;
   logic [20:0] minute_prod;
   logic [5:0]  minute;
   logic [5:0]  second;

   assign o_ready = !o_v_ff || rsp_chan.ready;
   assign b_ready = !b_v_ff || o_ready;
   assign a_ready = !a_v_ff || b_ready;
   assign in_ready = a_ready;

   assign hour_prod = 27'(a_rem_ff[16:4]) * 27'(HOUR_RECIP);
   assign hour = hour_prod[HOUR_RECIP_SHIFT +: 5];
   assign minute_prod = 21'(b_rest_ff[11:2]) * 21'(MINUTE_RECIP);
   assign minute = minute_prod[MINUTE_RECIP_SHIFT +: 6];
   assign second = 6'(b_rest_ff - 12'(minute) * 12'(MINUTE_SECONDS));

   always_comb begin
      a_v_in = a_ready ? in_valid : a_v_ff;
      b_v_in = b_ready ? a_v_ff : b_v_ff;
      o_v_in = o_ready ? b_v_ff : o_v_ff;
   end

   always_comb begin
      a_rem_in = a_rem_ff;
      a_tag_in = a_tag_ff;
      if (in_valid && a_ready) begin
         a_rem_in = 17'(in_data.cur_time - 32'(in_data.days) * 32'(DAY_SECONDS));
         a_tag_in.day = in_data.days[8:0];
         a_tag_in.halted = in_data.halted;
         a_tag_in.carry = in_data.carry;
      end
   end

   always_comb begin
      b_hour_in = b_hour_ff;
      b_rest_in = b_rest_ff;
      b_tag_in = b_tag_ff;
      if (a_v_ff && b_ready) begin
         b_hour_in = hour;
         b_rest_in = 12'(a_rem_ff - 17'(hour) * 17'(HOUR_SECONDS));
         b_tag_in = a_tag_ff;
      end
   end

   always_comb begin
      o_day_low_in = o_day_low_ff;
      o_day_high_in = o_day_high_ff;
      o_hours_in = o_hours_ff;
      o_minutes_in = o_minutes_ff;
      o_seconds_in = o_seconds_ff;
      if (b_v_ff && o_ready) begin
         o_day_low_in = b_tag_ff.day[7:0];
         o_day_high_in = {b_tag_ff.carry, b_tag_ff.halted, 5'b00000, b_tag_ff.day[8]};
         o_hours_in = hours_to_bcd(b_hour_ff);
         o_minutes_in = sexa_to_bcd(minute);
         o_seconds_in = sexa_to_bcd(second);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      a_rem_ff <= a_rem_in;
      a_tag_ff <= a_tag_in;
      b_hour_ff <= b_hour_in;
      b_rest_ff <= b_rest_in;
      b_tag_ff <= b_tag_in;
      o_day_low_ff <= o_day_low_in;
      o_day_high_ff <= o_day_high_in;
      o_hours_ff <= o_hours_in;
      o_minutes_ff <= o_minutes_in;
      o_seconds_ff <= o_seconds_in;
   end

   assign rsp_chan.valid = o_v_ff;
   assign rsp_chan.day_low_out = o_day_low_ff;
   assign rsp_chan.day_high_out = o_day_high_ff;
   assign rsp_chan.hours_bcd = o_hours_ff;
   assign rsp_chan.minutes_bcd = o_minutes_ff;
   assign rsp_chan.seconds_bcd = o_seconds_ff;

   assert property (@(posedge clock) disable iff (reset)
      a_v_ff |-> (a_rem_ff < DAY_SECONDS))
      else $error("time of day out of range after the day split");

endmodule

// File: sv/frame_clock_rtc_latch_core.sv
// Top level of the frame clock latch: request channel, state stage and BCD response channel.
//
//   channel   direction  handshake          contents
//   req_chan  in         valid/ready        frame count and the five host clock bytes
//   rsp_chan  out        valid/ready        latched day bytes and BCD hours, minutes, seconds
//   csr       in         csr_we             clock start time in seconds, no read-back
//
// One request is taken per cycle until every stage is full.
// The pipeline holds up to six requests: two input stages, the state stage, three split stages.
// A stalled response backs up stage by stage, and requests are taken until every stage is full.
// Reset is synchronous; afterwards the clock reads 10:00:00 at frame zero.
module frame_clock_rtc_latch_core (
   input  logic                            clock,
   input  logic                            reset,
   frc_req_if.sink                         req_chan,
   frc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [frc_pkg::START_WIDTH-1:0] csr_wdata
);
   import frc_pkg::*;

   logic      prep_valid;
   logic      prep_ready;
   prep_type  prep_data;
   logic      latch_valid;
   logic      latch_ready;
   latch_type latch_data;

   frc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   frc_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (latch_valid),
      .out_ready (latch_ready),
      .out_data  (latch_data)
   );

   frc_split u_split (
      .clock    (clock),
      .reset    (reset),
      .in_valid (latch_valid),
      .in_ready (latch_ready),
      .in_data  (latch_data),
      .rsp_chan (rsp_chan)
   );

endmodule
